### hw/rtl/i2crm_pkg.sv
// ----------------------------------------------------------------------------
// I2C register master package
// Shared item and result types, segment codes and the byte selection helpers.
// ----------------------------------------------------------------------------
package i2crm_pkg;

  // Depth of the queue between the front and the back.
  localparam int IQ_DEPTH_DEF = 2;

  // Operation codes of an input item.
  localparam logic [2:0] OP_TICK    = 3'd0;
  localparam logic [2:0] OP_WRITE   = 3'd1;
  localparam logic [2:0] OP_READ    = 3'd2;
  localparam logic [2:0] OP_LED_ON  = 3'd3;
  localparam logic [2:0] OP_LED_OFF = 3'd4;

  // Configuration register indexes.
  localparam logic CFG_EXPANDER_ADDRESS = 1'b0;
  localparam logic CFG_PHASE_TICKS      = 1'b1;

  // Register reset values.
  localparam logic [6:0] EXPANDER_ADDRESS_RST = 7'd33;
  localparam logic [7:0] PHASE_TICKS_RST      = 8'd1;

  // Segment kinds.
  localparam logic [2:0] K_IDLE  = 3'd0;
  localparam logic [2:0] K_START = 3'd1;
  localparam logic [2:0] K_TX    = 3'd2;
  localparam logic [2:0] K_ACK   = 3'd3;
  localparam logic [2:0] K_RX    = 3'd4;
  localparam logic [2:0] K_NACK  = 3'd5;
  localparam logic [2:0] K_STOP  = 3'd6;

  // Sequencer codes, one per bus segment.
  localparam logic [4:0] ST_IDLE          = 5'd0;
  localparam logic [4:0] ST_WRITE         = 5'd1;
  localparam logic [4:0] ST_WRITE_DEV     = 5'd2;
  localparam logic [4:0] ST_WRITE_DEV_ACK = 5'd3;
  localparam logic [4:0] ST_WRITE_REG     = 5'd4;
  localparam logic [4:0] ST_WRITE_REG_ACK = 5'd5;
  localparam logic [4:0] ST_WRITE_DAT     = 5'd6;
  localparam logic [4:0] ST_WRITE_DAT_ACK = 5'd7;
  localparam logic [4:0] ST_WRITE_END     = 5'd8;
  localparam logic [4:0] ST_READ          = 5'd9;
  localparam logic [4:0] ST_READ_DEV      = 5'd10;
  localparam logic [4:0] ST_READ_DEV_ACK  = 5'd11;
  localparam logic [4:0] ST_READ_REG      = 5'd12;
  localparam logic [4:0] ST_READ_REG_ACK  = 5'd13;
  localparam logic [4:0] ST_READ_RESTART  = 5'd14;
  localparam logic [4:0] ST_READ_DEVR     = 5'd15;
  localparam logic [4:0] ST_READ_DEVR_ACK = 5'd16;
  localparam logic [4:0] ST_READ_RX       = 5'd17;
  localparam logic [4:0] ST_READ_NACK     = 5'd18;
  localparam logic [4:0] ST_READ_END      = 5'd19;
  localparam logic [4:0] ST_LED           = 5'd20;
  localparam logic [4:0] ST_LED_DEV       = 5'd21;
  localparam logic [4:0] ST_LED_DEV_ACK   = 5'd22;
  localparam logic [4:0] ST_LED_LO        = 5'd23;
  localparam logic [4:0] ST_LED_LO_ACK    = 5'd24;
  localparam logic [4:0] ST_LED_HI        = 5'd25;
  localparam logic [4:0] ST_LED_HI_ACK    = 5'd26;
  localparam logic [4:0] ST_LED_END       = 5'd27;

  // One classified input item.
  typedef struct packed {
    logic [2:0]  operation;
    logic [6:0]  device_address;
    logic [7:0]  register_address;
    logic [15:0] write_data;
    logic        sda_in;
    logic        is_cmd;
  } item_t;

  // One result item.
  typedef struct packed {
    logic        scl;
    logic        sda_out;
    logic        sda_drive;
    logic        busy_res;
    logic [7:0]  read_data;
    logic        read_done;
    logic        rejected;
    logic [15:0] led_mask;
  } result_t;

  // Kind of each sequencer segment.
  function automatic logic [2:0] seg_kind(input logic [4:0] st);
    logic [2:0] k;
    k = K_IDLE;
    case (st)
      ST_WRITE, ST_READ, ST_READ_RESTART, ST_LED:            k = K_START;
      ST_WRITE_DEV, ST_WRITE_REG, ST_WRITE_DAT, ST_READ_DEV,
      ST_READ_REG, ST_READ_DEVR, ST_LED_DEV, ST_LED_LO,
      ST_LED_HI:                                             k = K_TX;
      ST_WRITE_DEV_ACK, ST_WRITE_REG_ACK, ST_WRITE_DAT_ACK,
      ST_READ_DEV_ACK, ST_READ_REG_ACK, ST_READ_DEVR_ACK,
      ST_LED_DEV_ACK, ST_LED_LO_ACK, ST_LED_HI_ACK:          k = K_ACK;
      ST_READ_RX:                                            k = K_RX;
      ST_READ_NACK:                                          k = K_NACK;
      ST_WRITE_END, ST_READ_END, ST_LED_END:                 k = K_STOP;
      default:                                               k = K_IDLE;
    endcase
    return k;
  endfunction

  // Number of phases in a segment of the given kind.
  function automatic logic [4:0] seg_len(input logic [2:0] kind);
    logic [4:0] n;
    n = 5'd1;
    case (kind)
      K_START, K_STOP: n = 5'd3;
      K_TX, K_RX:      n = 5'd16;
      K_ACK, K_NACK:   n = 5'd2;
      default:         n = 5'd1;
    endcase
    return n;
  endfunction

  // Byte shifted out by a transmit segment.
  function automatic logic [7:0] tx_byte(input logic [4:0]  st,
                                         input logic [6:0]  dev,
                                         input logic [7:0]  regi,
                                         input logic [15:0] data);
    logic [7:0] b;
    b = 8'h00;
    case (st)
      ST_WRITE_DEV, ST_READ_DEV, ST_LED_DEV: b = {dev, 1'b0};
      ST_WRITE_REG, ST_READ_REG:             b = regi;
      ST_WRITE_DAT:                          b = data[7:0];
      ST_READ_DEVR:                          b = {dev, 1'b1};
      ST_LED_LO:                             b = ~data[7:0];
      ST_LED_HI:                             b = ~data[15:8];
      default:                               b = 8'h00;
    endcase
    return b;
  endfunction

endpackage

### hw/rtl/i2crm_front.sv
// ----------------------------------------------------------------------------
// I2C register master front
// Accepts input items, marks commands and holds them in a short queue.
// ----------------------------------------------------------------------------
module i2crm_front import i2crm_pkg::*; #(
  parameter int IQ_DEPTH = IQ_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_push,
  output logic        in_full,
  input  logic [2:0]  in_operation,
  input  logic [6:0]  in_device_address,
  input  logic [7:0]  in_register_address,
  input  logic [15:0] in_write_data,
  input  logic        in_sda_in,
  output logic        q_valid,
  output item_t       q_item,
  input  logic        q_take
);

  localparam int PTR_W = (IQ_DEPTH > 1) ? $clog2(IQ_DEPTH) : 1;
  localparam int CNT_W = $clog2(IQ_DEPTH + 1);

  item_t             q_mem [IQ_DEPTH];
  logic [PTR_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic              push_ok;
  logic              take_ok;
  item_t             new_item;

  // Classify the arriving item.
  always_comb begin
    new_item.operation        = in_operation;
    new_item.device_address   = in_device_address;
    new_item.register_address = in_register_address;
    new_item.write_data       = in_write_data;
    new_item.sda_in           = in_sda_in;
    new_item.is_cmd           = (in_operation >= OP_WRITE) && (in_operation <= OP_LED_OFF);
  end

  assign in_full = (count_r == CNT_W'(IQ_DEPTH));
  assign q_valid = (count_r != '0);
  assign q_item  = q_mem[rd_ptr_r];
  assign push_ok = in_push && !in_full;
  assign take_ok = q_take && q_valid;

  // Pointer and fill count update.
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push_ok) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(IQ_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (take_ok) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(IQ_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push_ok && !take_ok) begin
      count_nxt = count_r + 1'b1;
    end else if (take_ok && !push_ok) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Queue storage.
  always_ff @(posedge clk) begin
    if (push_ok) begin
      q_mem[wr_ptr_r] <= new_item;
    end
  end

endmodule

### hw/rtl/i2crm_back.sv
// ----------------------------------------------------------------------------
// I2C register master back
// Runs the bit sequencer one item at a time and queues the result items.
// ----------------------------------------------------------------------------
module i2crm_back import i2crm_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        q_valid,
  input  item_t       q_item,
  output logic        q_take,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [7:0]  cfg_data,
  output logic        out_empty,
  input  logic        out_pop,
  output result_t     out_res
);

  // Configuration registers.
  logic [6:0]  exp_addr_r;
  logic [7:0]  phase_ticks_r;

  // Sequencer state.
  logic [4:0]  seq_r, seq_nxt;
  logic [3:0]  bc_r, bc_nxt;
  logic [7:0]  shift_r, shift_nxt;
  logic [1:0]  bi_r, bi_nxt;
  logic [7:0]  timer_r, timer_nxt;
  logic [2:0]  hcmd_r, hcmd_nxt;
  logic [6:0]  hdev_r, hdev_nxt;
  logic [7:0]  hreg_r, hreg_nxt;
  logic [15:0] hdata_r, hdata_nxt;
  logic [7:0]  recv_r, recv_nxt;
  logic [15:0] led_r, led_nxt;

  // Step temporaries.
  logic [4:0]  st0;
  logic [4:0]  st_next;
  logic [2:0]  kind;
  logic [2:0]  kind_new;
  logic [7:0]  t_inc;
  logic [7:0]  limit;
  logic [3:0]  bc_inc;
  logic [15:0] led_calc;
  logic        done;
  logic        rej;
  result_t     res;

  // Result queue, two entries.
  result_t     oq_mem [2];
  logic        oq_wr_r;
  logic        oq_rd_r;
  logic [1:0]  oq_cnt_r;
  logic        oq_pop_ok;

  assign q_take    = q_valid && (oq_cnt_r != 2'd2);
  assign out_empty = (oq_cnt_r == 2'd0);
  assign out_res   = oq_mem[oq_rd_r];
  assign oq_pop_ok = out_pop && !out_empty;

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      exp_addr_r    <= EXPANDER_ADDRESS_RST;
      phase_ticks_r <= PHASE_TICKS_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_EXPANDER_ADDRESS: exp_addr_r    <= cfg_data[6:0];
        default:              phase_ticks_r <= cfg_data;
      endcase
    end
  end

  // One sequencer step for the item at the head of the queue.
  always_comb begin
    seq_nxt   = seq_r;
    bc_nxt    = bc_r;
    shift_nxt = shift_r;
    bi_nxt    = bi_r;
    timer_nxt = timer_r;
    hcmd_nxt  = hcmd_r;
    hdev_nxt  = hdev_r;
    hreg_nxt  = hreg_r;
    hdata_nxt = hdata_r;
    recv_nxt  = recv_r;
    led_nxt   = led_r;
    done      = 1'b0;
    rej       = 1'b0;
    kind      = K_IDLE;
    kind_new  = K_IDLE;
    bc_inc    = bc_r + 4'd1;
    t_inc     = timer_r + 8'd1;
    limit     = (phase_ticks_r == 8'd0) ? 8'd1 : phase_ticks_r;
    st_next   = ST_IDLE;
    led_calc  = led_r;

    // Unused codes fall back to idle.
    st0     = (seg_kind(seq_r) == K_IDLE) ? ST_IDLE : seq_r;
    seq_nxt = st0;

    if (st0 == ST_IDLE) begin
      if (q_item.is_cmd) begin
        hcmd_nxt  = q_item.operation;
        hdev_nxt  = q_item.device_address;
        hreg_nxt  = q_item.register_address;
        hdata_nxt = q_item.write_data;
        bi_nxt    = 2'd0;
        bc_nxt    = 4'd0;
        timer_nxt = 8'd0;
        unique case (q_item.operation)
          OP_WRITE: seq_nxt = ST_WRITE;
          OP_READ:  seq_nxt = ST_READ;
          default: begin
            if (q_item.operation == OP_LED_ON) begin
              led_calc = led_r | q_item.write_data;
            end else begin
              led_calc = led_r & ~q_item.write_data;
            end
            led_nxt   = led_calc;
            hdata_nxt = led_calc;
            hdev_nxt  = exp_addr_r;
            seq_nxt   = ST_LED;
          end
        endcase
      end
    end else begin
      rej = q_item.is_cmd;
      if ((t_inc >= limit) || (t_inc == 8'd0)) begin
        // End of the current phase.
        kind      = seg_kind(st0);
        timer_nxt = 8'd0;
        bc_nxt    = bc_inc;
        if (bc_r[0] && (kind == K_TX)) begin
          shift_nxt = {shift_r[6:0], 1'b0};
        end else if (bc_r[0] && (kind == K_RX)) begin
          shift_nxt = {shift_r[6:0], q_item.sda_in};
        end
        if ((bc_inc == 4'd0) || ({1'b0, bc_inc} >= seg_len(kind))) begin
          // End of the segment.
          if ((kind == K_TX) || (kind == K_RX)) begin
            bi_nxt = bi_r + 2'd1;
          end
          if (kind == K_RX) begin
            recv_nxt = shift_nxt;
          end
          if ((st0 == ST_WRITE_END) || (st0 == ST_READ_END) || (st0 == ST_LED_END)) begin
            seq_nxt = ST_IDLE;
            bc_nxt  = 4'd0;
            bi_nxt  = 2'd0;
            done    = (st0 == ST_READ_END);
          end else begin
            st_next  = st0 + 5'd1;
            seq_nxt  = st_next;
            bc_nxt   = 4'd0;
            kind_new = seg_kind(st_next);
            if (kind_new == K_TX) begin
              shift_nxt = tx_byte(st_next, hdev_r, hreg_r, hdata_r);
            end else if (kind_new == K_RX) begin
              shift_nxt = 8'h00;
            end
          end
        end
      end else begin
        timer_nxt = t_inc;
      end
    end
  end

  // Line levels and status after the step.
  always_comb begin
    res.scl       = bc_nxt[0];
    res.sda_out   = 1'b1;
    res.sda_drive = 1'b1;
    unique case (seg_kind(seq_nxt))
      K_START: begin
        res.scl     = (bc_nxt != 4'd0);
        res.sda_out = (bc_nxt != 4'd2);
      end
      K_STOP: begin
        res.scl     = (bc_nxt != 4'd0);
        res.sda_out = (bc_nxt == 4'd2);
      end
      K_TX:         res.sda_out   = shift_nxt[7];
      K_ACK, K_RX:  res.sda_drive = 1'b0;
      K_NACK:       res.sda_out   = 1'b1;
      default:      res.scl       = 1'b1;
    endcase
    res.busy_res  = (seq_nxt != ST_IDLE);
    res.read_data = recv_nxt;
    res.read_done = done;
    res.rejected  = rej;
    res.led_mask  = led_nxt;
  end

  // Sequencer registers advance once per item taken.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seq_r   <= ST_IDLE;
      bc_r    <= '0;
      shift_r <= '0;
      bi_r    <= '0;
      timer_r <= '0;
      hcmd_r  <= OP_TICK;
      hdev_r  <= '0;
      hreg_r  <= '0;
      hdata_r <= '0;
      recv_r  <= '0;
      led_r   <= '0;
    end else if (q_take) begin
      seq_r   <= seq_nxt;
      bc_r    <= bc_nxt;
      shift_r <= shift_nxt;
      bi_r    <= bi_nxt;
      timer_r <= timer_nxt;
      hcmd_r  <= hcmd_nxt;
      hdev_r  <= hdev_nxt;
      hreg_r  <= hreg_nxt;
      hdata_r <= hdata_nxt;
      recv_r  <= recv_nxt;
      led_r   <= led_nxt;
    end
  end

  // Result queue control.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      oq_wr_r  <= 1'b0;
      oq_rd_r  <= 1'b0;
      oq_cnt_r <= 2'd0;
    end else begin
      if (q_take) begin
        oq_wr_r <= ~oq_wr_r;
      end
      if (oq_pop_ok) begin
        oq_rd_r <= ~oq_rd_r;
      end
      if (q_take && !oq_pop_ok) begin
        oq_cnt_r <= oq_cnt_r + 2'd1;
      end else if (oq_pop_ok && !q_take) begin
        oq_cnt_r <= oq_cnt_r - 2'd1;
      end
    end
  end

  // Result queue storage.
  always_ff @(posedge clk) begin
    if (q_take) begin
      oq_mem[oq_wr_r] <= res;
    end
  end

endmodule

### hw/rtl/i2c_register_master.sv
// Items pass the front queue and a sequencer step; results leave by the out_ ports.
// Throughput: one item per cycle while the result queue has room; each item is one step.
// The front queue and the two-entry result queue let either side stall without loss.
// Reset: rst_n low at a clock edge empties both queues, idles the sequencer,
// clears the LED mask and restores expander address 33 and one tick per phase.
// ----------------------------------------------------------------------------
// I2C register master top level
// Bit-level I2C master advanced by tick items, with an LED expander mask.
// ----------------------------------------------------------------------------
module i2c_register_master import i2crm_pkg::*; #(
  parameter int IQ_DEPTH = IQ_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_push,
  output logic        in_full,
  input  logic [2:0]  in_operation,
  input  logic [6:0]  in_device_address,
  input  logic [7:0]  in_register_address,
  input  logic [15:0] in_write_data,
  input  logic        in_sda_in,
  output logic        out_empty,
  input  logic        out_pop,
  output logic        out_scl,
  output logic        out_sda_out,
  output logic        out_sda_drive,
  output logic        out_busy_res,
  output logic [7:0]  out_read_data,
  output logic        out_read_done,
  output logic        out_rejected,
  output logic [15:0] out_led_mask,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [7:0]  cfg_data
);

  logic    q_valid;
  logic    q_take;
  item_t   q_item;
  result_t res;

  // Front: accept and classify items.
  i2crm_front #(.IQ_DEPTH(IQ_DEPTH)) u_front (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_push             (in_push),
    .in_full             (in_full),
    .in_operation        (in_operation),
    .in_device_address   (in_device_address),
    .in_register_address (in_register_address),
    .in_write_data       (in_write_data),
    .in_sda_in           (in_sda_in),
    .q_valid             (q_valid),
    .q_item              (q_item),
    .q_take              (q_take)
  );

  // Back: bit sequencer and result queue.
  i2crm_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_item    (q_item),
    .q_take    (q_take),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_res   (res)
  );

  assign out_scl       = res.scl;
  assign out_sda_out   = res.sda_out;
  assign out_sda_drive = res.sda_drive;
  assign out_busy_res  = res.busy_res;
  assign out_read_data = res.read_data;
  assign out_read_done = res.read_done;
  assign out_rejected  = res.rejected;
  assign out_led_mask  = res.led_mask;

endmodule

### bench/i2c_register_master_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// I2C register master testbench
// Drives tick and command items into the bit-level I2C master, predicts the bus
// levels and status of every result item, and compares them field by field.
// ----------------------------------------------------------------------------
module i2c_register_master_test;
  import i2crm_pkg::*;

  // Operation codes outside the defined set; the block treats them as ticks.
  localparam logic [2:0] OP_UNUSED_LO = 3'd5;
  localparam logic [2:0] OP_UNUSED_HI = 3'd7;

  // How the SDA input is chosen for the ticks of a transaction.
  localparam int SDA_LOW    = 0;
  localparam int SDA_HIGH   = 1;
  localparam int SDA_RANDOM = 2;

  localparam int RANDOM_ITEMS = 400;
  localparam int STALL_LIMIT  = 2000;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_push;
  logic        in_full;
  logic [2:0]  in_operation;
  logic [6:0]  in_device_address;
  logic [7:0]  in_register_address;
  logic [15:0] in_write_data;
  logic        in_sda_in;
  logic        out_empty;
  logic        out_pop;
  logic        out_scl;
  logic        out_sda_out;
  logic        out_sda_drive;
  logic        out_busy_res;
  logic [7:0]  out_read_data;
  logic        out_read_done;
  logic        out_rejected;
  logic [15:0] out_led_mask;
  logic        cfg_we;
  logic        cfg_index;
  logic [7:0]  cfg_data;

  i2c_register_master dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_push             (in_push),
    .in_full             (in_full),
    .in_operation        (in_operation),
    .in_device_address   (in_device_address),
    .in_register_address (in_register_address),
    .in_write_data       (in_write_data),
    .in_sda_in           (in_sda_in),
    .out_empty           (out_empty),
    .out_pop             (out_pop),
    .out_scl             (out_scl),
    .out_sda_out         (out_sda_out),
    .out_sda_drive       (out_sda_drive),
    .out_busy_res        (out_busy_res),
    .out_read_data       (out_read_data),
    .out_read_done       (out_read_done),
    .out_rejected        (out_rejected),
    .out_led_mask        (out_led_mask),
    .cfg_we              (cfg_we),
    .cfg_index           (cfg_index),
    .cfg_data            (cfg_data)
  );

  // 20 ns clock.
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Idling controls shared by the sender and the result checker.
  int send_idle_pct   = 0;
  int recv_stall_pct  = 0;
  int pop_hold_cycles = 0;

  // Run bookkeeping.
  int mismatches    = 0;
  int working_items = 0;
  int started_txns  = 0;
  int reads_done    = 0;
  int refused_cmds  = 0;

  // Bus levels and status expected for items already accepted.
  result_t expected_levels[$];

  // Predicted configuration of the block.
  logic [6:0]  exp_addr;
  logic [7:0]  ticks_per_phase;

  // Predicted sequencer state.
  logic [4:0]  seq_st;
  logic [3:0]  phase_idx;
  logic [7:0]  shifter;
  logic [1:0]  byte_cnt;
  logic [7:0]  tick_cnt;
  logic [6:0]  held_dev;
  logic [7:0]  held_reg;
  logic [15:0] held_val;
  logic [7:0]  rx_byte;
  logic [15:0] led_bits;

  // ------------------------------------------------------------------------
  // Bus sequencer prediction
  // ------------------------------------------------------------------------

  // Kind of bus segment that a sequencer code stands for.
  function automatic logic [2:0] kind_of(input logic [4:0] st);
    logic [2:0] k;
    case (st)
      ST_WRITE, ST_READ, ST_READ_RESTART, ST_LED: k = K_START;
      ST_WRITE_DEV, ST_WRITE_REG, ST_WRITE_DAT, ST_READ_DEV, ST_READ_REG,
      ST_READ_DEVR, ST_LED_DEV, ST_LED_LO, ST_LED_HI: k = K_TX;
      ST_WRITE_DEV + 5'd1, ST_WRITE_REG + 5'd1, ST_WRITE_DAT + 5'd1,
      ST_READ_DEV + 5'd1, ST_READ_REG + 5'd1, ST_READ_DEVR + 5'd1,
      ST_LED_DEV + 5'd1, ST_LED_LO + 5'd1, ST_LED_HI + 5'd1: k = K_ACK;
      ST_READ_RX: k = K_RX;
      ST_READ_NACK: k = K_NACK;
      ST_WRITE_END, ST_READ_END, ST_LED_END: k = K_STOP;
      default: k = K_IDLE;
    endcase
    return k;
  endfunction

  // Number of SCL/SDA phases in a segment.
  function automatic int phases_in(input logic [2:0] k);
    int n;
    if (k == K_START || k == K_STOP) n = 3;
    else if (k == K_TX || k == K_RX) n = 16;
    else if (k == K_ACK || k == K_NACK) n = 2;
    else n = 1;
    return n;
  endfunction

  // Byte that a transmit segment shifts out, MSB first.
  function automatic logic [7:0] byte_for(input logic [4:0] st);
    logic [15:0] inverted;
    logic [7:0]  b;
    inverted = ~held_val;
    b = 8'h00;
    if (st == ST_WRITE_DEV || st == ST_READ_DEV || st == ST_LED_DEV) b = {held_dev, 1'b0};
    else if (st == ST_READ_DEVR) b = {held_dev, 1'b1};
    else if (st == ST_WRITE_REG || st == ST_READ_REG) b = held_reg;
    else if (st == ST_WRITE_DAT) b = held_val[7:0];
    else if (st == ST_LED_LO) b = inverted[7:0];
    else if (st == ST_LED_HI) b = inverted[15:8];
    return b;
  endfunction

  function automatic void begin_segment(input logic [4:0] st);
    seq_st    = st;
    phase_idx = 4'd0;
    tick_cnt  = 8'd0;
    if (kind_of(st) == K_TX) shifter = byte_for(st);
    else if (kind_of(st) == K_RX) shifter = 8'h00;
  endfunction

  // Closes the current phase; returns 1 when a read transaction has just ended.
  function automatic logic advance_phase(input logic sda);
    logic [2:0] k;
    logic       finished;
    k = kind_of(seq_st);
    finished = 1'b0;
    // Data moves on the end of the SCL high phase.
    if (phase_idx[0]) begin
      if (k == K_TX) shifter = {shifter[6:0], 1'b0};
      else if (k == K_RX) shifter = {shifter[6:0], sda};
    end
    phase_idx = phase_idx + 4'd1;
    tick_cnt  = 8'd0;
    if (phase_idx == 4'd0 || phase_idx >= phases_in(k)) begin
      if (k == K_TX || k == K_RX) byte_cnt = byte_cnt + 2'd1;
      if (k == K_RX) rx_byte = shifter;
      if (seq_st == ST_WRITE_END || seq_st == ST_READ_END || seq_st == ST_LED_END) begin
        finished  = (seq_st == ST_READ_END);
        seq_st    = ST_IDLE;
        phase_idx = 4'd0;
        byte_cnt  = 2'd0;
      end else begin
        begin_segment(seq_st + 5'd1);
      end
    end
    return finished;
  endfunction

  function automatic void reset_bus_model();
    exp_addr        = EXPANDER_ADDRESS_RST;
    ticks_per_phase = PHASE_TICKS_RST;
    seq_st    = ST_IDLE;
    phase_idx = 4'd0;
    shifter   = 8'h00;
    byte_cnt  = 2'd0;
    tick_cnt  = 8'd0;
    held_dev  = 7'd0;
    held_reg  = 8'd0;
    held_val  = 16'd0;
    rx_byte   = 8'd0;
    led_bits  = 16'd0;
  endfunction

  // Steps the sequencer by one accepted item and queues the expected result.
  function automatic void predict_bus_levels(input logic [2:0] op, input logic [6:0] dev,
                                             input logic [7:0] ra, input logic [15:0] wd,
                                             input logic sda);
    result_t    r;
    logic       is_cmd;
    logic [7:0] limit;
    logic [2:0] k;
    is_cmd = (op >= OP_WRITE) && (op <= OP_LED_OFF);
    r = '0;
    if (kind_of(seq_st) == K_IDLE) seq_st = ST_IDLE;

    if (seq_st == ST_IDLE) begin
      // An idle sequencer takes a command; ticks and unknown codes do nothing.
      if (is_cmd) begin
        held_dev = dev;
        held_reg = ra;
        held_val = wd;
        byte_cnt = 2'd0;
        working_items++;
        started_txns++;
        if (op == OP_WRITE) begin
          begin_segment(ST_WRITE);
        end else if (op == OP_READ) begin
          begin_segment(ST_READ);
        end else begin
          if (op == OP_LED_ON) led_bits = led_bits | wd;
          else led_bits = led_bits & ~wd;
          held_val = led_bits;
          held_dev = exp_addr;
          begin_segment(ST_LED);
        end
      end
    end else begin
      // A busy sequencer counts every item as a tick and refuses commands.
      working_items++;
      limit = (ticks_per_phase == 8'd0) ? 8'd1 : ticks_per_phase;
      r.rejected = is_cmd;
      if (is_cmd) refused_cmds++;
      tick_cnt = tick_cnt + 8'd1;
      if (tick_cnt >= limit || tick_cnt == 8'd0) r.read_done = advance_phase(sda);
      if (r.read_done) reads_done++;
    end

    // Line levels after the item.
    k = kind_of(seq_st);
    r.scl       = phase_idx[0];
    r.sda_out   = 1'b1;
    r.sda_drive = 1'b1;
    case (k)
      K_START: begin
        r.scl     = (phase_idx != 4'd0);
        r.sda_out = (phase_idx != 4'd2);
      end
      K_STOP: begin
        r.scl     = (phase_idx != 4'd0);
        r.sda_out = (phase_idx == 4'd2);
      end
      K_TX: r.sda_out = shifter[7];
      K_ACK, K_RX: r.sda_drive = 1'b0;
      K_NACK: ;
      default: r.scl = 1'b1;
    endcase
    r.busy_res  = (seq_st != ST_IDLE);
    r.read_data = rx_byte;
    r.led_mask  = led_bits;
    expected_levels.push_back(r);
  endfunction

  // ------------------------------------------------------------------------
  // Input side
  // ------------------------------------------------------------------------

  // Offers one item, idling first at random, and predicts it once accepted.
  task automatic send_item(input logic [2:0] op, input logic [6:0] dev,
                           input logic [7:0] ra, input logic [15:0] wd, input logic sda);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_push <= 1'b0;
      @(negedge clk);
    end
    in_push             <= 1'b1;
    in_operation        <= op;
    in_device_address   <= dev;
    in_register_address <= ra;
    in_write_data       <= wd;
    in_sda_in           <= sda;
    @(posedge clk);
    while (in_full) @(posedge clk);
    predict_bus_levels(op, dev, ra, wd, sda);
  endtask

  // One tick item, sometimes replaced by a command or an unknown code.
  task automatic send_tick(input int sda_sel, input int noise_pct);
    logic [2:0] op;
    logic       sda;
    op = OP_TICK;
    if ($urandom_range(99) < noise_pct) op = 3'($urandom_range(OP_UNUSED_HI, OP_WRITE));
    sda = (sda_sel == SDA_RANDOM) ? 1'($urandom_range(1)) : (sda_sel == SDA_HIGH);
    send_item(op, 7'($urandom_range(127)), 8'($urandom_range(255)),
              16'($urandom_range(65535)), sda);
  endtask

  // A command followed by ticks until the predicted sequencer is idle again.
  task automatic run_transaction(input logic [2:0] op, input logic [6:0] dev,
                                 input logic [7:0] ra, input logic [15:0] wd,
                                 input int sda_sel, input int noise_pct);
    send_item(op, dev, ra, wd, 1'($urandom_range(1)));
    while (seq_st != ST_IDLE) send_tick(sda_sel, noise_pct);
  endtask

  // Stops offering items and waits until every expected result has been taken.
  task automatic quiesce();
    @(negedge clk);
    in_push <= 1'b0;
    while (expected_levels.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_register(input logic idx, input logic [7:0] value);
    quiesce();
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    if (idx == CFG_EXPANDER_ADDRESS) exp_addr = value[6:0];
    else ticks_per_phase = value;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_idling(input int send_pct, input int recv_pct);
    send_idle_pct  = send_pct;
    recv_stall_pct = recv_pct;
  endtask

  // ------------------------------------------------------------------------
  // Result side
  // ------------------------------------------------------------------------

  task automatic compare_field(input string name, input logic [15:0] want,
                               input logic [15:0] got);
    if (want !== got) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      mismatches++;
    end
  endtask

  // Pops results at random, or holds off on request, and checks each one.
  initial begin : result_checker
    result_t want;
    out_pop = 1'b0;
    forever begin
      @(negedge clk);
      if (pop_hold_cycles > 0) begin
        out_pop <= 1'b0;
        pop_hold_cycles--;
      end else begin
        out_pop <= ($urandom_range(99) >= recv_stall_pct);
      end
      @(posedge clk);
      if (out_pop && !out_empty) begin
        if (expected_levels.size() == 0) begin
          $error("result item with no item waiting for it");
          mismatches++;
        end else begin
          want = expected_levels.pop_front();
          compare_field("scl", 16'(want.scl), 16'(out_scl));
          compare_field("sda_out", 16'(want.sda_out), 16'(out_sda_out));
          compare_field("sda_drive", 16'(want.sda_drive), 16'(out_sda_drive));
          compare_field("busy_res", 16'(want.busy_res), 16'(out_busy_res));
          compare_field("read_data", 16'(want.read_data), 16'(out_read_data));
          compare_field("read_done", 16'(want.read_done), 16'(out_read_done));
          compare_field("rejected", 16'(want.rejected), 16'(out_rejected));
          compare_field("led_mask", want.led_mask, out_led_mask);
        end
      end
    end
  end

  // Ends the run when nothing moves on either side for too long.
  initial begin : stall_watchdog
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_push && !in_full) || (out_pop && !out_empty) || cfg_we) quiet = 0;
      else quiet++;
    end
    $display("Nothing accepted for %0d cycles", STALL_LIMIT);
    $display("i2c_register_master_test: FAIL");
    $finish;
  end

  // ------------------------------------------------------------------------
  // Tests
  // ------------------------------------------------------------------------

  // Ticks and unknown codes on an idle sequencer leave the lines idle.
  task automatic test_idle_lines();
    send_item(OP_TICK, 7'h7F, 8'hFF, 16'hFFFF, 1'b1);
    send_item(OP_UNUSED_HI, 7'h7F, 8'hFF, 16'hFFFF, 1'b1);
    send_item(OP_UNUSED_LO, 7'h00, 8'h00, 16'h0000, 1'b0);
  endtask

  task automatic test_register_write();
    run_transaction(OP_WRITE, 7'h7F, 8'hFF, 16'hFFFF, SDA_RANDOM, 0);
    run_transaction(OP_WRITE, 7'h00, 8'h00, 16'h0000, SDA_LOW, 0);
  endtask

  // Reads with SDA held high and low give the two extreme bytes.
  task automatic test_register_read();
    run_transaction(OP_READ, 7'h7F, 8'hFF, 16'hFFFF, SDA_HIGH, 0);
    run_transaction(OP_READ, 7'h00, 8'h00, 16'h0000, SDA_LOW, 0);
  endtask

  task automatic test_led_mask();
    run_transaction(OP_LED_ON, 7'h00, 8'h00, 16'hFFFF, SDA_RANDOM, 0);
    run_transaction(OP_LED_OFF, 7'h7F, 8'hFF, 16'h00FF, SDA_RANDOM, 0);
    run_transaction(OP_LED_OFF, 7'h00, 8'h00, 16'hFFFF, SDA_RANDOM, 0);
    run_transaction(OP_LED_ON, 7'h00, 8'h00, 16'h0000, SDA_RANDOM, 0);
    run_transaction(OP_LED_ON, 7'h2A, 8'h55, 16'hA5C3, SDA_RANDOM, 0);
  endtask

  // Commands and unknown codes arriving in the middle of a transaction.
  task automatic test_busy_commands();
    run_transaction(OP_WRITE, 7'($urandom_range(127)), 8'($urandom_range(255)),
                    16'($urandom_range(65535)), SDA_RANDOM, 30);
    run_transaction(OP_READ, 7'($urandom_range(127)), 8'($urandom_range(255)),
                    16'($urandom_range(65535)), SDA_RANDOM, 30);
    run_transaction(OP_LED_OFF, 7'($urandom_range(127)), 8'($urandom_range(255)),
                    16'($urandom_range(65535)), SDA_RANDOM, 30);
  endtask

  // Expander address extremes and phase lengths of zero, two and the maximum.
  task automatic test_configuration();
    write_register(CFG_EXPANDER_ADDRESS, 8'h00);
    run_transaction(OP_LED_ON, 7'h7F, 8'hFF, 16'h0F0F, SDA_RANDOM, 0);
    write_register(CFG_EXPANDER_ADDRESS, 8'hFF);
    run_transaction(OP_LED_OFF, 7'h00, 8'h00, 16'h0303, SDA_RANDOM, 0);
    write_register(CFG_PHASE_TICKS, 8'h00);
    run_transaction(OP_WRITE, 7'h55, 8'hAA, 16'h5AA5, SDA_RANDOM, 10);
    write_register(CFG_PHASE_TICKS, 8'h02);
    run_transaction(OP_READ, 7'h2A, 8'h55, 16'h0000, SDA_RANDOM, 10);
    set_idling(0, 0);
    // One whole phase at the longest setting, then the rest at one tick a phase.
    write_register(CFG_PHASE_TICKS, 8'hFF);
    send_item(OP_LED_ON, 7'h00, 8'h00, 16'hF0F0, 1'b1);
    repeat (256) send_tick(SDA_RANDOM, 0);
    write_register(CFG_PHASE_TICKS, PHASE_TICKS_RST);
    while (seq_st != ST_IDLE) send_tick(SDA_RANDOM, 0);
  endtask

  // The receiver holds off while the sender keeps offering, filling the queues.
  task automatic test_queue_backpressure();
    set_idling(0, 0);
    quiesce();
    pop_hold_cycles = 300;
    run_transaction(OP_READ, 7'($urandom_range(127)), 8'($urandom_range(255)),
                    16'($urandom_range(65535)), SDA_RANDOM, 10);
  endtask

  // Mostly well-formed transactions with random content, some noise on top.
  task automatic test_random_traffic();
    int base;
    int txn;
    int done_items;
    int r;
    base = working_items;
    txn = 0;
    done_items = 0;
    while (done_items < RANDOM_ITEMS) begin
      case ((done_items / (RANDOM_ITEMS / 4)) % 4)
        0: set_idling(0, 0);
        1: set_idling(66, 0);
        2: set_idling(0, 66);
        default: set_idling(33, 33);
      endcase
      // Change both settings every sixth pass of the loop, mostly to short phases.
      if (txn % 6 == 5) begin
        r = $urandom_range(9);
        if (r < 6) write_register(CFG_PHASE_TICKS, 8'd1);
        else if (r < 9) write_register(CFG_PHASE_TICKS, 8'($urandom_range(4, 2)));
        else write_register(CFG_PHASE_TICKS, 8'($urandom_range(12, 5)));
        write_register(CFG_EXPANDER_ADDRESS, 8'($urandom_range(255)));
      end
      if ($urandom_range(99) < 8) begin
        if ($urandom_range(1)) send_tick(SDA_RANDOM, 0);
        else send_item(3'($urandom_range(OP_UNUSED_HI, OP_UNUSED_LO)),
                       7'($urandom_range(127)), 8'($urandom_range(255)),
                       16'($urandom_range(65535)), 1'($urandom_range(1)));
      end else begin
        run_transaction(3'($urandom_range(OP_LED_OFF, OP_WRITE)), 7'($urandom_range(127)),
                        8'($urandom_range(255)), 16'($urandom_range(65535)), SDA_RANDOM,
                        $urandom_range(1) ? 8 : 0);
      end
      txn++;
      done_items = working_items - base;
    end
  endtask

  // ------------------------------------------------------------------------
  // Main sequence
  // ------------------------------------------------------------------------
  initial begin
    rst_n               = 1'b0;
    in_push             = 1'b0;
    in_operation        = OP_TICK;
    in_device_address   = 7'd0;
    in_register_address = 8'd0;
    in_write_data       = 16'd0;
    in_sda_in           = 1'b0;
    cfg_we              = 1'b0;
    cfg_index           = CFG_EXPANDER_ADDRESS;
    cfg_data            = 8'd0;
    reset_bus_model();
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_idle_lines();
    test_register_write();
    set_idling(33, 33);
    test_register_read();
    test_led_mask();
    test_busy_commands();
    test_configuration();
    test_queue_backpressure();
    test_random_traffic();
    quiesce();

    $display("Covered %0d working items and %0d transactions, %0d of them completed reads,",
             working_items, started_txns, reads_done);
    $display("with %0d commands refused while busy and phase lengths from 0 to 255 ticks.",
             refused_cmds);
    if (mismatches == 0 && expected_levels.size() == 0) begin
      $display("i2c_register_master_test: PASS");
    end else begin
      $display("i2c_register_master_test: FAIL");
    end
    $finish;
  end

endmodule

### files.f
hw/rtl/i2crm_pkg.sv
hw/rtl/i2crm_front.sv
hw/rtl/i2crm_back.sv
hw/rtl/i2c_register_master.sv
bench/i2c_register_master_test.sv
